/* hdl/psu_pkg.sv */
`timescale 1ns / 1ps
// shared types and constants for the png scanline unfilter
// no dependencies

package psu_pkg;

    localparam int CFG_AW      = 2;
    localparam int CFG_DW      = 16;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_LIMIT = 3;
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_AW-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_HAS_ALPHA    = 2'd2;

    localparam logic [2:0] FILT_NONE  = 3'd0;
    localparam logic [2:0] FILT_SUB   = 3'd1;
    localparam logic [2:0] FILT_UP    = 3'd2;
    localparam logic [2:0] FILT_AVG   = 3'd3;
    localparam logic [2:0] FILT_PAETH = 3'd4;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

    typedef struct packed {
        logic       bad;
        logic [7:0] raw;
        logic [2:0] filter;
        logic [1:0] ch;
        logic       first_row;
        logic       row_first;
        logic       img_end;
        logic       two;
    } psu_cmd_t;

endpackage

/* hdl/psu_row_mem.sv */
`timescale 1ns / 1ps
// previous-row byte store, one write port and one registered read port
// depends on nothing

module psu_row_mem #(
    parameter int AW = 14
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    localparam int DEPTH = 1 << AW;

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/psu_queue.sv */
`timescale 1ns / 1ps
// short command queue between the front and back parts
// depends on psu_pkg

module psu_queue
    import psu_pkg::*;
#(
    parameter int DW = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  logic [DW-1:0]       push_data,
    input  logic                pop,
    output logic                head_valid,
    output logic [DW-1:0]       head_data,
    output logic [QUEUE_CW-1:0] count
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    logic [DW-1:0]       slot_reg [QUEUE_DEPTH];
    logic [PW-1:0]       wr_ptr_reg;
    logic [PW-1:0]       rd_ptr_reg;
    logic [QUEUE_CW-1:0] count_reg;
    logic [QUEUE_CW-1:0] count_next;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head_valid = (count_reg != '0);
    assign head_data  = slot_reg[rd_ptr_reg];
    assign count      = count_reg;

endmodule

/* hdl/psu_front.sv */
`timescale 1ns / 1ps
// front part: configuration registers, row and column tracking,
// filter byte decode and store read issue; depends on psu_pkg

module psu_front
    import psu_pkg::*;
#(
    parameter int MAX_WIDTH = 4096,
    parameter int AW        = 14
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [CFG_AW-1:0]   cfg_addr,
    input  logic [CFG_DW-1:0]   cfg_wdata,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,
    input  logic [QUEUE_CW-1:0] q_count,
    output logic                rd_en,
    output logic [AW-1:0]       rd_addr,
    output logic                push,
    output psu_cmd_t            push_cmd,
    output logic [AW-1:0]       push_addr
);

    localparam int LW = AW + 1;

    logic [12:0]   width_reg;
    logic [15:0]   height_reg;
    logic          alpha_reg;
    logic [AW-1:0] col_reg;
    logic [1:0]    ch3_reg;
    logic [15:0]   row_count_reg;
    logic [2:0]    filter_reg;
    logic          expect_reg;
    logic          first_row_reg;
    logic          drop_reg;
    logic          pend_valid_reg;
    psu_cmd_t      pend_cmd_reg;
    logic [AW-1:0] pend_addr_reg;

    logic          accept;
    logic [LW-1:0] wcap;
    logic [LW-1:0] row_len;
    logic [15:0]   h_eff;
    logic [1:0]    ch;
    logic          row_end;
    logic          img_end;
    logic          is_data;
    psu_cmd_t      cmd_next;
    logic          pend_next;

    assign s_tready = ({1'b0, q_count} + {{QUEUE_CW{1'b0}}, pend_valid_reg})
                      < (QUEUE_CW + 1)'(QUEUE_LIMIT);
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        if (width_reg == '0)
        begin
            wcap = LW'(1);
        end
        else if (32'(width_reg) > MAX_WIDTH)
        begin
            wcap = LW'(MAX_WIDTH);
        end
        else
        begin
            wcap = LW'(width_reg);
        end
        row_len = alpha_reg ? (wcap << 2) : ((wcap << 1) + wcap);
        h_eff   = (height_reg == '0) ? 16'd1 : height_reg;
        ch      = alpha_reg ? col_reg[1:0] : ch3_reg;
        row_end = ({1'b0, col_reg} + LW'(1)) >= row_len;
        img_end = row_end && (({1'b0, row_count_reg} + 17'd1) >= {1'b0, h_eff});
        is_data = !expect_reg && !drop_reg;
    end

    always_comb
    begin
        cmd_next           = '0;
        cmd_next.raw       = s_tdata;
        cmd_next.filter    = filter_reg;
        cmd_next.ch        = ch;
        cmd_next.first_row = first_row_reg;
        cmd_next.row_first = (col_reg == '0);
        cmd_next.img_end   = img_end;
        cmd_next.two       = !alpha_reg && (ch3_reg == 2'd2);
        pend_next          = 1'b0;
        if (accept)
        begin
            if (expect_reg)
            begin
                if (!drop_reg && (s_tdata > {5'd0, FILT_PAETH}))
                begin
                    cmd_next.bad = 1'b1;
                    pend_next    = 1'b1;
                end
            end
            else if (!drop_reg)
            begin
                pend_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg      <= 13'd1;
            height_reg     <= 16'd1;
            alpha_reg      <= 1'b1;
            col_reg        <= '0;
            ch3_reg        <= '0;
            row_count_reg  <= '0;
            filter_reg     <= FILT_NONE;
            expect_reg     <= 1'b1;
            first_row_reg  <= 1'b1;
            drop_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    CFG_IMAGE_WIDTH:  width_reg  <= cfg_wdata[12:0];
                    CFG_IMAGE_HEIGHT: height_reg <= cfg_wdata[15:0];
                    CFG_HAS_ALPHA:    alpha_reg  <= cfg_wdata[0];
                    default:          ;
                endcase
            end
            pend_valid_reg <= pend_next;
            if (accept)
            begin
                if (expect_reg)
                begin
                    expect_reg <= 1'b0;
                    col_reg    <= '0;
                    ch3_reg    <= '0;
                    if (!drop_reg)
                    begin
                        if (s_tdata > {5'd0, FILT_PAETH})
                        begin
                            drop_reg <= 1'b1;
                        end
                        else
                        begin
                            filter_reg <= s_tdata[2:0];
                        end
                    end
                end
                else if (row_end)
                begin
                    col_reg       <= '0;
                    ch3_reg       <= '0;
                    expect_reg    <= 1'b1;
                    first_row_reg <= img_end;
                    if (img_end)
                    begin
                        row_count_reg <= '0;
                        drop_reg      <= 1'b0;
                    end
                    else
                    begin
                        row_count_reg <= row_count_reg + 16'd1;
                    end
                end
                else
                begin
                    col_reg <= col_reg + 1'b1;
                    ch3_reg <= (ch3_reg == 2'd2) ? 2'd0 : ch3_reg + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pend_next)
        begin
            pend_cmd_reg  <= cmd_next;
            pend_addr_reg <= col_reg;
        end
    end

    assign rd_en     = accept && is_data;
    assign rd_addr   = col_reg;
    assign push      = pend_valid_reg;
    assign push_cmd  = pend_cmd_reg;
    assign push_addr = pend_addr_reg;

endmodule

/* hdl/psu_back.sv */
`timescale 1ns / 1ps
// back part: predictor, left and upper-left byte registers, store write
// and output register with alpha insertion; depends on psu_pkg

module psu_back
    import psu_pkg::*;
#(
    parameter int AW = 14
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          head_valid,
    input  psu_cmd_t      head_cmd,
    input  logic [7:0]    head_above,
    input  logic [AW-1:0] head_addr,
    output logic          pop,
    output logic          wr_en,
    output logic [AW-1:0] wr_addr,
    output logic [7:0]    wr_data,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [7:0]    m_tdata,
    output logic          m_tlast,
    output logic [1:0]    m_tuser
);

    function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                         input logic [7:0] c);
        logic signed [9:0] da;
        logic signed [9:0] db;
        logic signed [9:0] dc;
        logic [9:0]        pa;
        logic [9:0]        pb;
        logic [9:0]        pc;
        da = $signed({2'b00, b}) - $signed({2'b00, c});
        db = $signed({2'b00, a}) - $signed({2'b00, c});
        dc = da + db;
        pa = (da < 0) ? 10'(-da) : 10'(da);
        pb = (db < 0) ? 10'(-db) : 10'(db);
        pc = (dc < 0) ? 10'(-dc) : 10'(dc);
        if (pa <= pb && pa <= pc)
        begin
            return a;
        end
        return (pb <= pc) ? b : c;
    endfunction

    logic [7:0] left_reg [4];
    logic [7:0] up_reg   [4];
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       out_last_reg;
    logic       out_done_reg;
    logic       out_bad_reg;
    logic       alpha_pend_reg;
    logic       alpha_done_reg;

    logic       load;
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] c;
    logic [8:0] avg_sum;
    logic [7:0] pred;
    logic [7:0] v;

    assign load = !out_valid_reg || m_tready;
    assign pop  = head_valid && load && !alpha_pend_reg;

    always_comb
    begin
        a       = head_cmd.row_first ? 8'd0 : left_reg[head_cmd.ch];
        c       = head_cmd.row_first ? 8'd0 : up_reg[head_cmd.ch];
        b       = head_cmd.first_row ? 8'd0 : head_above;
        avg_sum = {1'b0, a} + {1'b0, b};
        unique case (head_cmd.filter)
            FILT_SUB:   pred = a;
            FILT_UP:    pred = b;
            FILT_AVG:   pred = avg_sum[8:1];
            FILT_PAETH: pred = paeth(a, b, c);
            default:    pred = 8'd0;
        endcase
        v = head_cmd.raw + pred;
    end

    assign wr_en   = pop && !head_cmd.bad;
    assign wr_addr = head_addr;
    assign wr_data = v;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 4; k++)
            begin
                left_reg[k] <= '0;
                up_reg[k]   <= '0;
            end
            out_valid_reg  <= 1'b0;
            alpha_pend_reg <= 1'b0;
            alpha_done_reg <= 1'b0;
        end
        else
        begin
            if (pop && !head_cmd.bad)
            begin
                for (int k = 0; k < 4; k++)
                begin
                    if (2'(k) == head_cmd.ch)
                    begin
                        left_reg[k] <= v;
                        up_reg[k]   <= b;
                    end
                    else if (head_cmd.row_first)
                    begin
                        left_reg[k] <= '0;
                        up_reg[k]   <= '0;
                    end
                end
            end
            if (load)
            begin
                if (alpha_pend_reg)
                begin
                    out_valid_reg  <= 1'b1;
                    alpha_pend_reg <= 1'b0;
                end
                else if (pop)
                begin
                    out_valid_reg <= 1'b1;
                    if (!head_cmd.bad && head_cmd.two)
                    begin
                        alpha_pend_reg <= 1'b1;
                        alpha_done_reg <= head_cmd.img_end;
                    end
                end
                else
                begin
                    out_valid_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            if (alpha_pend_reg)
            begin
                out_byte_reg <= ALPHA_OPAQUE;
                out_last_reg <= 1'b1;
                out_done_reg <= alpha_done_reg;
                out_bad_reg  <= 1'b0;
            end
            else if (pop)
            begin
                if (head_cmd.bad)
                begin
                    out_byte_reg <= 8'd0;
                    out_last_reg <= 1'b1;
                    out_done_reg <= 1'b0;
                    out_bad_reg  <= 1'b1;
                end
                else
                begin
                    out_byte_reg <= v;
                    out_last_reg <= !head_cmd.two;
                    out_done_reg <= head_cmd.img_end && !head_cmd.two;
                    out_bad_reg  <= 1'b0;
                end
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = {out_bad_reg, out_done_reg};

endmodule

/* hdl/png_scanline_unfilter.sv */
`timescale 1ns / 1ps
// top level of the png scanline unfilter for 8-bit truecolor rows
// depends on psu_pkg, psu_front, psu_queue, psu_row_mem, psu_back
//
//  port group | direction | carries
//  s_*        | in        | one inflated byte per item: filter type or filtered sample
//  m_*        | out       | one rgba byte per item, tlast on the last byte of an input item
//  cfg_*      | in        | register writes: image width, image height, alpha flag
//
// one input byte per cycle while the queue is below its limit; an rgb blue byte
// yields two output items and holds the queue head for the alpha byte. an item
// passes the front register, the store read into the queue and the output register.
// the row store needs no clearing after reset; the first row ignores its reads.
// either side may stall; the queue absorbs up to three items in flight.

module png_scanline_unfilter
    import psu_pkg::*;
#(
    parameter int MAX_WIDTH = 4096
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [CFG_AW-1:0] cfg_addr,
    input  logic [CFG_DW-1:0] cfg_wdata,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // raw_byte
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,   // out_byte
    output logic              m_tlast,
    output logic [1:0]        m_tuser    // bad_filter, image_done
);

    localparam int STORE_DEPTH = 4 * MAX_WIDTH;
    localparam int AW          = $clog2(STORE_DEPTH);
    localparam int CW          = $bits(psu_cmd_t);
    localparam int QW          = AW + 8 + CW;

    logic                rd_en;
    logic [AW-1:0]       rd_addr;
    logic [7:0]          rd_data;
    logic                push;
    psu_cmd_t            push_cmd;
    logic [AW-1:0]       push_addr;
    logic                pop;
    logic                head_valid;
    logic [QW-1:0]       head_data;
    logic [QUEUE_CW-1:0] q_count;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [7:0]          wr_data;
    psu_cmd_t            head_cmd;

    psu_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .AW        (AW)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .q_count   (q_count),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .push      (push),
        .push_cmd  (push_cmd),
        .push_addr (push_addr)
    );

    psu_row_mem #(
        .AW (AW)
    ) u_row_mem (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    psu_queue #(
        .DW (QW)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  ({push_addr, rd_data, push_cmd}),
        .pop        (pop),
        .head_valid (head_valid),
        .head_data  (head_data),
        .count      (q_count)
    );

    assign head_cmd = head_data[CW-1:0];

    psu_back #(
        .AW (AW)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .head_above (head_data[CW+7:CW]),
        .head_addr  (head_data[QW-1:CW+8]),
        .pop        (pop),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

endmodule
